FILE: rtl/core/address_range_hit_histogram_core_macros.svh
// assertion macros shared by the histogram core rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ADDRESS_RANGE_HIT_HISTOGRAM_CORE_MACROS_SVH
`define ADDRESS_RANGE_HIT_HISTOGRAM_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define AHH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AHH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define AHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ahh_pkg.sv
// types, constants and helpers for the address range hit histogram core
// used by ahh_div and address_range_hit_histogram_core
package ahh_pkg;

    localparam int NUM_BINS = 4096;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    localparam int PCT_SCALE_W = 7;
    localparam int DIV_NW      = 32 + PCT_SCALE_W;
    localparam int DIV_CW      = $clog2(DIV_NW);

    localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = PCT_SCALE_W'(100);
    localparam logic [15:0]            PCT_MAX   = 16'hFFFF;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_HIGH = 2'd1;
    localparam logic [1:0] CFG_STEP = 2'd2;

    localparam logic [2:0] STS_COUNTED  = 3'd0;
    localparam logic [2:0] STS_OUTSIDE  = 3'd1;
    localparam logic [2:0] STS_DISABLED = 3'd2;
    localparam logic [2:0] STS_CAPACITY = 3'd3;
    localparam logic [2:0] STS_READ_OK  = 3'd4;
    localparam logic [2:0] STS_BAD_IDX  = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_IDX_DIV,
        ST_ADDR,
        ST_READ,
        ST_PCT_MUL,
        ST_PCT_DIV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [31:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

FILE: rtl/core/ahh_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ahh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ahh_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ahh_pkg and the core macros header
`include "address_range_hit_histogram_core_macros.svh"
module ahh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ahh_pkg::t_div_req i_req,
    output ahh_pkg::t_div_rsp o_rsp
);
    import ahh_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_dsr;
    logic [DIV_NW-1:0] r_quo;

    logic [32:0] rem_sh;
    logic        q_bit;
    logic [32:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NW-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        q_bit   = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[DIV_NW-2:0], q_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

    `AHH_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted while busy")
    `AHH_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while still busy")

endmodule

FILE: rtl/core/address_range_hit_histogram_core.sv
// Sampling histogram of code addresses. After reset the core sweeps its 4096-entry bin
// memory to zero, one entry a cycle, with the input stalled; configuration writes are
// taken throughout. Items are worked on one at a time. For a counted address the 39-step
// bit-serial divider is run twice, once for the bin index and once for the percentage,
// with a read-modify-write of the bin memory between. A bin read runs the divider once,
// for the percentage, and an address beyond the bins once, for the index; an end-of-sample
// or rejected item does not use it. With a zero total the percentage run is skipped.
// A finished result sits in an output register, so the next word is accepted while it waits.
`include "address_range_hit_histogram_core_macros.svh"
module address_range_hit_histogram_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_pc,
    input  logic [15:0] i_weight,
    input  logic [11:0] i_bin_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_hits,
    output logic [15:0] o_percent,
    output logic [31:0] o_bin_address,
    output logic [31:0] o_total_hits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ahh_pkg::*;

    t_state            r_state, n_state;
    logic [BIN_AW-1:0] r_clr, n_clr;
    logic [31:0]       r_low, r_high, r_step;
    logic [31:0]       r_total, n_total;
    logic [1:0]        r_cmd, n_cmd;
    logic [31:0]       r_pc, n_pc;
    logic [15:0]       r_weight, n_weight;
    logic [11:0]       r_bidx, n_bidx;
    logic [31:0]       r_idx, n_idx;
    logic [31:0]       r_hits, n_hits;
    logic [31:0]       r_addr, n_addr;
    logic [15:0]       r_pct, n_pct;
    logic [2:0]        r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_hits, n_out_hits;
    logic [15:0]       r_out_pct, n_out_pct;
    logic [31:0]       r_out_addr, n_out_addr;
    logic [31:0]       r_out_total, n_out_total;

    logic              mem_we;
    logic [BIN_AW-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic              mem_re;
    logic [BIN_AW-1:0] mem_raddr;
    logic [31:0]       mem_rdata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic              enabled;
    logic [31:0]       idx_mul;
    logic [31:0]       upd_hits;
    logic [DIV_NW-1:0] pct_prod;

    ahh_ram #(
        .WIDTH(32),
        .DEPTH(NUM_BINS)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    ahh_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign enabled  = (r_high > r_low) && (r_step != 32'd0);
    assign idx_mul  = r_idx * r_step;
    assign upd_hits = sat_add(mem_rdata, r_weight);
    assign pct_prod = DIV_NW'(r_hits) * DIV_NW'(PCT_SCALE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 32'd0;
            r_high <= 32'd0;
            r_step <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW:  r_low  <= i_cfg_data;
                CFG_HIGH: r_high <= i_cfg_data;
                CFG_STEP: r_step <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_total     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pc         <= n_pc;
        r_weight     <= n_weight;
        r_bidx       <= n_bidx;
        r_idx        <= n_idx;
        r_hits       <= n_hits;
        r_addr       <= n_addr;
        r_pct        <= n_pct;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_hits   <= n_out_hits;
        r_out_pct    <= n_out_pct;
        r_out_addr   <= n_out_addr;
        r_out_total  <= n_out_total;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_total      = r_total;
        n_cmd        = r_cmd;
        n_pc         = r_pc;
        n_weight     = r_weight;
        n_bidx       = r_bidx;
        n_idx        = r_idx;
        n_hits       = r_hits;
        n_addr       = r_addr;
        n_pct        = r_pct;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_hits   = r_out_hits;
        n_out_pct    = r_out_pct;
        n_out_addr   = r_out_addr;
        n_out_total  = r_out_total;
        o_in_stall   = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[BIN_AW-1:0];
        mem_wdata    = upd_hits;
        mem_re       = 1'b0;
        mem_raddr    = r_idx[BIN_AW-1:0];
        div_req      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 32'd0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == BIN_AW'(NUM_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_pc     = i_pc;
                    n_weight = i_weight;
                    n_bidx   = i_bin_index;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_hits   = 32'd0;
                n_addr   = 32'd0;
                n_pct    = 16'd0;
                n_status = STS_DISABLED;
                n_state  = ST_RESULT;
                unique case (r_cmd)
                    CMD_COUNT: begin
                        if (!enabled) begin
                            n_status = STS_DISABLED;
                        end else if (r_pc < r_low || r_pc >= r_high) begin
                            n_status = STS_OUTSIDE;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_NW'(r_pc - r_low);
                            div_req.divisor  = r_step;
                            n_status         = STS_COUNTED;
                            n_state          = ST_IDX_DIV;
                        end
                    end
                    CMD_END: begin
                        if (enabled) begin
                            n_total  = sat_add(r_total, r_weight);
                            n_status = STS_COUNTED;
                        end
                    end
                    CMD_READ: begin
                        if (32'(r_bidx) >= 32'(NUM_BINS)) begin
                            n_status = STS_BAD_IDX;
                        end else begin
                            n_idx    = 32'(r_bidx);
                            n_status = STS_READ_OK;
                            n_state  = ST_ADDR;
                        end
                    end
                    default: n_status = STS_DISABLED;
                endcase
            end
            ST_IDX_DIV: begin
                if (div_rsp.done) begin
                    n_idx   = div_rsp.quotient[31:0];
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_addr = r_low + idx_mul;
                if (r_cmd == CMD_COUNT && r_idx >= 32'(NUM_BINS)) begin
                    n_status = STS_CAPACITY;
                    n_state  = ST_RESULT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_cmd == CMD_COUNT) begin
                    mem_we = 1'b1;
                    n_hits = upd_hits;
                end else begin
                    n_hits = mem_rdata;
                end
                n_state = ST_PCT_MUL;
            end
            ST_PCT_MUL: begin
                if (r_total == 32'd0) begin
                    n_pct   = 16'd0;
                    n_state = ST_RESULT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = pct_prod;
                    div_req.divisor  = r_total;
                    n_state          = ST_PCT_DIV;
                end
            end
            ST_PCT_DIV: begin
                if (div_rsp.done) begin
                    n_pct   = (div_rsp.quotient > DIV_NW'(PCT_MAX)) ? PCT_MAX
                                                                    : div_rsp.quotient[15:0];
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_hits   = r_hits;
                    n_out_pct    = r_pct;
                    n_out_addr   = r_addr;
                    n_out_total  = r_total;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_hits        = r_out_hits;
    assign o_percent     = r_out_pct;
    assign o_bin_address = r_out_addr;
    assign o_total_hits  = r_out_total;

    `AHH_ASSERT_IMPL(a_we_src, i_clk, i_rst_n, mem_we, r_state == ST_CLEAR || (r_state == ST_READ && r_cmd == CMD_COUNT), "bin write outside clear or update")
    `AHH_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, r_state == ST_RESULT && r_out_valid && i_out_stall, r_state == ST_RESULT, "pending result overwritten")
    `AHH_ASSERT_NEXT(a_total_only_end, i_clk, i_rst_n, r_state == ST_DECODE && r_cmd != CMD_END, $stable(r_total), "total changed by a non end-of-sample word")

endmodule
